// ===== src/spbq_pkg.sv =====
// Shared types and constants for the strict-priority band queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package spbq_pkg;

  localparam int CMD_W      = 2;
  localparam int PRIO_W     = 8;
  localparam int TAG_W      = 16;
  localparam int STATUS_W   = 2;
  localparam int BAND_OUT_W = 3;
  localparam int LIMIT_W    = 7;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic [CMD_W-1:0] CMD_SUBMIT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLOSE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CLOSED      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 2'd3;

  // register index, taken from paddr[2]
  localparam logic REG_QUEUE_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_RESP
  } spbq_state_e;

  typedef struct packed {
    logic load;   // capture the incoming request
    logic exec;   // carry out the captured request
  } spbq_cmd_t;

endpackage

`default_nettype wire

// ===== src/spbq_ctrl.sv =====
// Controller FSM: sequences capture, execution and result hand-off.
// Depends on spbq_pkg.
`default_nettype none

module spbq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output spbq_pkg::spbq_cmd_t     cmd_o
);
  import spbq_pkg::*;

  spbq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      FSM_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = FSM_RESP;
      end
      FSM_RESP: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/spbq_dpath.sv =====
// Datapath: band FIFO pointers and counts, tag memory, priority encoder
// and result registers. Depends on spbq_pkg.
`default_nettype none

module spbq_dpath #(
  parameter int BANDS    = 8,
  parameter int CAPACITY = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire spbq_pkg::spbq_cmd_t               cmd_i,
  input  wire logic [spbq_pkg::LIMIT_W-1:0]      queue_limit_i,
  input  wire logic [spbq_pkg::CMD_W-1:0]        req_cmd_i,
  input  wire logic [spbq_pkg::PRIO_W-1:0]       req_prio_i,
  input  wire logic [spbq_pkg::TAG_W-1:0]        req_tag_i,
  output logic      [spbq_pkg::STATUS_W-1:0]     status_o,
  output logic      [spbq_pkg::TAG_W-1:0]        popped_tag_o,
  output logic      [spbq_pkg::BAND_OUT_W-1:0]   popped_band_o,
  output logic                                   drained_o
);
  import spbq_pkg::*;

  localparam int BAND_W = $clog2(BANDS);
  localparam int PTR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int DEPTH  = BANDS * CAPACITY;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [CMD_W-1:0]  cmd_q;
  logic [PRIO_W-1:0] prio_q;
  logic [TAG_W-1:0]  tag_q;

  logic [PTR_W-1:0] head_q  [BANDS];
  logic [PTR_W-1:0] tail_q  [BANDS];
  logic [CNT_W-1:0] count_q [BANDS];
  logic [CNT_W-1:0] total_q, total_d;
  logic             closed_q, closed_d;

  logic [TAG_W-1:0] mem [DEPTH];
  logic [TAG_W-1:0] rdata_q;

  logic [STATUS_W-1:0] status_q, status_d;
  logic                pop_ok_q;
  logic [BAND_W-1:0]   band_q;
  logic                drained_q;

  logic              top_found;
  logic [BAND_W-1:0] top_band;
  logic [BAND_W-1:0] clamp_band;
  logic [BAND_W-1:0] band_sel;
  logic [CMP_W-1:0]  limit_eff;
  logic [LIMIT_W-1:0] limit_nz;
  logic              submit_ok;
  logic              pop_ok;
  logic [PTR_W-1:0]  ptr;
  logic [PTR_W:0]    ptr_inc;
  logic [PTR_W-1:0]  ptr_next;
  logic [ADDR_W-1:0] mem_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= req_cmd_i;
      prio_q <= req_prio_i;
      tag_q  <= req_tag_i;
    end
  end

  always_comb begin
    top_found = 1'b0;
    top_band  = '0;
    for (int b = 0; b < BANDS; b++) begin
      if (count_q[b] != '0) begin
        top_found = 1'b1;
        top_band  = BAND_W'(b);
      end
    end
  end

  always_comb begin
    if ($signed(prio_q) < $signed(PRIO_W'(0))) begin
      clamp_band = '0;
    end else if ($signed(prio_q) > $signed(PRIO_W'(BANDS - 1))) begin
      clamp_band = BAND_W'(BANDS - 1);
    end else begin
      clamp_band = prio_q[BAND_W-1:0];
    end
  end

  always_comb begin
    limit_nz  = (queue_limit_i == '0) ? LIMIT_W'(1) : queue_limit_i;
    limit_eff = CMP_W'(limit_nz);
    if (limit_eff > CMP_W'(CAPACITY)) begin
      limit_eff = CMP_W'(CAPACITY);
    end
  end

  assign band_sel  = (cmd_q == CMD_SUBMIT) ? clamp_band : top_band;
  assign submit_ok = (cmd_q == CMD_SUBMIT) && !closed_q && (CMP_W'(total_q) < limit_eff);
  assign pop_ok    = (cmd_q == CMD_POP) && top_found;
  assign ptr       = (cmd_q == CMD_SUBMIT) ? tail_q[band_sel] : head_q[band_sel];
  assign ptr_inc   = {1'b0, ptr} + (PTR_W + 1)'(1);
  assign ptr_next  = (ptr_inc == (PTR_W + 1)'(CAPACITY)) ? '0 : ptr_inc[PTR_W-1:0];
  assign mem_addr  = ADDR_W'(band_sel) * ADDR_W'(CAPACITY) + ADDR_W'(ptr);

  always_comb begin
    status_d = ST_OK;
    total_d  = total_q;
    closed_d = closed_q;
    case (cmd_q)
      CMD_SUBMIT: begin
        if (closed_q) begin
          status_d = ST_CLOSED;
        end else if (!submit_ok) begin
          status_d = ST_FULL;
        end else begin
          total_d = total_q + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (!top_found) begin
          status_d = ST_EMPTY;
        end else begin
          total_d = total_q - CNT_W'(1);
        end
      end
      CMD_CLOSE: begin
        closed_d = 1'b1;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BANDS; b++) begin
        head_q[b]  <= '0;
        tail_q[b]  <= '0;
        count_q[b] <= '0;
      end
      total_q   <= '0;
      closed_q  <= 1'b0;
      status_q  <= ST_OK;
      pop_ok_q  <= 1'b0;
      band_q    <= '0;
      drained_q <= 1'b0;
    end else if (cmd_i.exec) begin
      if (submit_ok) begin
        tail_q[band_sel]  <= ptr_next;
        count_q[band_sel] <= count_q[band_sel] + CNT_W'(1);
      end
      if (pop_ok) begin
        head_q[band_sel]  <= ptr_next;
        count_q[band_sel] <= count_q[band_sel] - CNT_W'(1);
      end
      total_q   <= total_d;
      closed_q  <= closed_d;
      status_q  <= status_d;
      pop_ok_q  <= pop_ok;
      band_q    <= pop_ok ? band_sel : '0;
      drained_q <= closed_d && (total_d == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && submit_ok) begin
      mem[mem_addr] <= tag_q;
    end
    if (cmd_i.exec && pop_ok) begin
      rdata_q <= mem[mem_addr];
    end
  end

  assign status_o      = status_q;
  assign popped_tag_o  = pop_ok_q ? rdata_q : '0;
  assign popped_band_o = BAND_OUT_W'(band_q);
  assign drained_o     = drained_q;

endmodule

`default_nettype wire

// ===== src/strict_priority_band_queue.sv =====
// Top level: APB limit register, controller and datapath.
// Depends on spbq_pkg, spbq_ctrl and spbq_dpath.
//
//   channel   direction  handshake                 fields
//   in        sink       in_valid_i / in_stall_o   cmd, priority_req, task_tag
//   out       source     out_valid_o / out_stall_i status, popped_tag, popped_band, drained
//   apb       slave      psel/penable/pready       queue_limit at byte address 0
//
// Each request passes through three steps: capture, execute (one tag memory access,
// priority encode over band counts), then the result register is offered.
// A new request is taken once the previous result has been taken.
// Reset empties every band and opens the queue; no clearing pass is needed.
// A stalled result holds its value until taken.
`default_nettype none

module strict_priority_band_queue #(
  parameter int BANDS    = 8,
  parameter int CAPACITY = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [spbq_pkg::CMD_W-1:0]          cmd_i,
  input  wire logic [spbq_pkg::PRIO_W-1:0]         priority_req_i,
  input  wire logic [spbq_pkg::TAG_W-1:0]          task_tag_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic      [spbq_pkg::STATUS_W-1:0]       status_o,
  output logic      [spbq_pkg::TAG_W-1:0]          popped_tag_o,
  output logic      [spbq_pkg::BAND_OUT_W-1:0]     popped_band_o,
  output logic                                     drained_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [spbq_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [spbq_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [spbq_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready
);
  import spbq_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  spbq_cmd_t          cmd;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_QUEUE_LIMIT)) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_QUEUE_LIMIT) ? APB_DATA_W'(limit_q) : '0;

  spbq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  spbq_dpath #(
    .BANDS    (BANDS),
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .queue_limit_i (limit_q),
    .req_cmd_i     (cmd_i),
    .req_prio_i    (priority_req_i),
    .req_tag_i     (task_tag_i),
    .status_o      (status_o),
    .popped_tag_o  (popped_tag_o),
    .popped_band_o (popped_band_o),
    .drained_o     (drained_o)
  );

endmodule

`default_nettype wire
